FILE: rtl/core/tmco_pkg.sv
// Package: shared types and constants of the tent-map oscillator.
`default_nettype none
package tmco_pkg;

  // Operation codes of the shared iterative unit
  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG,
    ST_DIV,
    ST_DIV_WAIT,
    ST_CURVE,
    ST_POW,
    ST_POW_WAIT,
    ST_FRAC,
    ST_SQ_WAIT,
    ST_FMUL,
    ST_FMUL_WAIT,
    ST_MAG,
    ST_MAG_WAIT,
    ST_EMIT
  } seq_state_t;

  localparam logic [0:0]  REG_SAMPLE_RATE   = 1'b0;
  localparam logic [18:0] SAMPLE_RATE_RESET = 19'd48000;
  localparam logic [17:0] COEF_TWO          = 18'd131072;
  localparam logic [17:0] COEF_ONE          = 18'd65536;
  localparam logic [16:0] COEF_MAX          = 17'd131065;
  localparam logic [15:0] EXP_ONE           = 16'd4096;
  localparam int          OUT_FRAC          = 22;
  localparam int          OUT_MAX           = 8388607;
  localparam int          OUT_MIN           = -8388608;

endpackage
`default_nettype wire

FILE: rtl/core/tmco_alu.sv
// Shared iterative unit: shift-add multiply, restoring divide, digit-by-digit square root.
`default_nettype none
module tmco_alu #(
  parameter int FRAC_BITS = 22,
  localparam int W = 2 * FRAC_BITS + 19
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tmco_pkg::alu_cmd_t cmd,
  input  wire logic [W-1:0]       opa,
  input  wire logic [W-1:0]       opb,
  output logic [W-1:0]            result,
  output tmco_pkg::alu_stat_t     stat
);
  import tmco_pkg::*;

  localparam int PW = FRAC_BITS + 2;
  localparam int DL = FRAC_BITS + 16;
  localparam int RL = FRAC_BITS + 1;
  localparam int CW = $clog2(DL + 1);

  alu_op_t        op_q;
  logic           busy;
  logic           done;
  logic [CW-1:0]  cnt;
  logic [W-1:0]   src;
  logic [W-1:0]   acc;
  logic [W-1:0]   quo;
  logic [W-1:0]   mcand;
  logic [W-1:0]   x;
  logic [W-1:0]   y;
  logic           sub;
  logic [W:0]     sum;
  logic           ge;

  // one adder serves every step; with sub set its carry is x >= y
  always_comb begin
    unique case (op_q)
      ALU_MUL: begin
        x   = {acc[W-2:0], 1'b0};
        y   = src[W-1] ? mcand : '0;
        sub = 1'b0;
      end
      ALU_DIV: begin
        x   = {acc[W-2:0], src[W-1]};
        y   = mcand;
        sub = 1'b1;
      end
      ALU_SQRT: begin
        x   = {acc[W-3:0], src[W-1:W-2]};
        y   = {quo[W-3:0], 2'b01};
        sub = 1'b1;
      end
      default: begin
        x   = '0;
        y   = '0;
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{W{1'b0}}, sub};
    ge  = sum[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_q <= ALU_MUL;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
        op_q <= cmd.op;
        unique case (cmd.op)
          ALU_MUL:  cnt <= CW'(PW);
          ALU_DIV:  cnt <= CW'(DL);
          ALU_SQRT: cnt <= CW'(RL);
          default:  cnt <= CW'(PW);
        endcase
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !busy) begin
      acc   <= '0;
      quo   <= '0;
      mcand <= opb;
      unique case (cmd.op)
        ALU_MUL:  src <= opa << (W - PW);
        ALU_DIV:  src <= opa << (W - DL);
        ALU_SQRT: src <= opa << (W - 2 * RL);
        default:  src <= opa;
      endcase
    end else if (busy) begin
      unique case (op_q)
        ALU_MUL: begin
          acc <= sum[W-1:0];
          src <= src << 1;
        end
        ALU_DIV: begin
          acc <= ge ? sum[W-1:0] : x;
          quo <= {quo[W-2:0], ge};
          src <= src << 1;
        end
        ALU_SQRT: begin
          acc <= ge ? sum[W-1:0] : x;
          quo <= {quo[W-2:0], ge};
          src <= src << 2;
        end
        default: ;
      endcase
    end
  end

  assign result    = (op_q == ALU_MUL) ? (acc >> FRAC_BITS) : quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

FILE: rtl/core/tent_map_chaotic_oscillator.sv
// Top level: tent-map chaotic oscillator with sequencer and configuration port.
`default_nettype none
// One beat on the item channel yields one beat on the sample channel. Each item
// is worked by a small sequencer around a single iterative unit that does a
// shift-add multiply (FRAC_BITS+2 steps), a restoring divide (FRAC_BITS+16
// steps) or a square root (FRAC_BITS+1 steps), and the block is not ready while
// it runs. The phase-step divide is skipped for a zero frequency. An exponent of
// exactly 0 or 1.0 needs no further steps; any other exponent adds a multiply
// per unit of its integer part, a square root per fractional position down to
// its lowest set bit, and a multiply per set fractional bit. A finished sample
// is held in an output register, so the next item is taken while it waits; the
// sequencer only stalls if a second sample is ready before the first is taken.
// The single register, sample_rate, sits at byte address 0 and resets to 48000;
// write it only while the block is idle.
module tent_map_chaotic_oscillator #(
  parameter int FRAC_BITS = 22
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [23:0] freq_hz,
  input  wire logic [17:0] tent_coef,
  input  wire logic [15:0] curve_exp,
  output logic             sample_valid,
  input  wire logic        sample_ready,
  output logic [23:0]      sample,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tmco_pkg::*;

  localparam int W    = 2 * FRAC_BITS + 19;
  localparam int PW   = FRAC_BITS + 2;      // phase reaches 2.0
  localparam int VW   = FRAC_BITS + 1;      // segment end points stay below 1.0
  localparam int RW   = FRAC_BITS + 17;     // curve may grow to 2^16
  localparam int SUMW = RW + 2;
  localparam int OW   = SUMW + 10;
  localparam int LSH  = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam int RSH  = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam longint unsigned ONE_L  = 64'd1 << FRAC_BITS;
  localparam longint unsigned INIT_V = (ONE_L * 4) / 5;
  localparam longint unsigned INIT_P = (ONE_L * 11) / 10;
  localparam logic [VW-1:0] ONE_V  = VW'(ONE_L);
  localparam logic [VW-1:0] HALF_V = VW'(ONE_L / 2);
  localparam logic [PW-1:0] ONE_P  = PW'(ONE_L);

  // ---------------------------------------------------------------- config
  logic [18:0] sample_rate;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SAMPLE_RATE) ? 32'(sample_rate) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SAMPLE_RATE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SAMPLE_RATE)) begin
      sample_rate <= pwdata[18:0];
    end
  end

  // ---------------------------------------------------------------- state
  seq_state_t     state;
  seq_state_t     state_next;
  alu_cmd_t       alu_cmd;
  alu_stat_t      alu_stat;
  logic [W-1:0]   alu_a;
  logic [W-1:0]   alu_b;
  logic [W-1:0]   alu_res;

  logic [23:0]    freq_q;
  logic [17:0]    coef_q;
  logic [15:0]    exp_q;
  logic [VW-1:0]  next_value;
  logic [VW-1:0]  previous_value;
  logic [PW-1:0]  phase;
  logic [15:0]    held_exponent;
  logic [RW-1:0]  curve;
  logic [PW-1:0]  root;
  logic [3:0]     pow_left;
  logic [11:0]    frac_left;
  logic [RW-1:0]  mag;

  // ---------------------------------------------------------------- segment maths
  logic [16:0]          coef_cl;
  logic [VW-1:0]        tent_x;
  logic [VW+16:0]       tent_prod;
  logic [VW-1:0]        tent_next;
  logic signed [VW:0]   gap;
  logic                 gap_neg;
  logic [VW-1:0]        gap_mag;
  logic [W-1:0]         step_sat;

  always_comb begin
    priority if (coef_q >= COEF_TWO) coef_cl = COEF_MAX;
    else if (coef_q < COEF_ONE)      coef_cl = COEF_ONE[16:0];
    else                             coef_cl = coef_q[16:0];

    // fold the upper half of the map onto 1 - x
    if (next_value >= HALF_V) begin
      tent_x = (next_value <= ONE_V) ? ONE_V - next_value : '0;
    end else begin
      tent_x = next_value;
    end
    tent_prod = (VW + 17)'(coef_cl) * (VW + 17)'(tent_x);
    tent_next = VW'(tent_prod >> 16);

    // the gap is always next minus previous, so derive it rather than store it
    gap     = $signed({1'b0, next_value}) - $signed({1'b0, previous_value});
    gap_neg = gap[VW];
    gap_mag = gap_neg ? VW'(-gap) : gap[VW-1:0];

    step_sat = (alu_res > W'(ONE_L)) ? W'(ONE_L) : alu_res;
  end

  // ---------------------------------------------------------------- output maths
  logic signed [SUMW-1:0] prev_s;
  logic signed [SUMW-1:0] mag_s;
  logic signed [SUMW-1:0] sum_s;
  logic signed [OW-1:0]   out_w;
  logic [23:0]            sample_next;

  always_comb begin
    prev_s = $signed(SUMW'(previous_value));
    mag_s  = $signed(SUMW'(mag));
    sum_s  = gap_neg ? prev_s - mag_s : prev_s + mag_s;
    // rescale to 22 fraction bits; arithmetic shift rounds towards minus infinity
    out_w  = (OW'(sum_s) <<< LSH) >>> RSH;
    priority if (out_w > OW'(OUT_MAX)) sample_next = 24'h7FFFFF;
    else if (out_w < OW'(OUT_MIN))     sample_next = 24'h800000;
    else                               sample_next = out_w[23:0];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    alu_cmd.start = 1'b0;
    alu_cmd.op    = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    item_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) state_next = ST_SEG;
      end
      ST_SEG: state_next = ST_DIV;
      ST_DIV: begin
        if (freq_q == 24'd0) begin
          state_next = ST_CURVE;
        end else if (!alu_stat.busy) begin
          alu_cmd.start = 1'b1;
          alu_cmd.op    = ALU_DIV;
          alu_a         = W'(freq_q) << (FRAC_BITS - 8);
          alu_b         = W'(sample_rate);
          state_next    = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: if (alu_stat.done) state_next = ST_CURVE;
      ST_CURVE: begin
        if (held_exponent == 16'd0 || held_exponent == EXP_ONE) state_next = ST_MAG;
        else                                                   state_next = ST_POW;
      end
      ST_POW: begin
        if (pow_left == 4'd0) begin
          state_next = ST_FRAC;
        end else if (!alu_stat.busy) begin
          alu_cmd.start = 1'b1;
          alu_a         = W'(phase);
          alu_b         = W'(curve);
          state_next    = ST_POW_WAIT;
        end
      end
      ST_POW_WAIT: if (alu_stat.done) state_next = ST_POW;
      ST_FRAC: begin
        if (frac_left == 12'd0) begin
          state_next = ST_MAG;
        end else if (!alu_stat.busy) begin
          alu_cmd.start = 1'b1;
          alu_cmd.op    = ALU_SQRT;
          alu_a         = W'(root) << FRAC_BITS;
          state_next    = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: begin
        if (alu_stat.done) state_next = frac_left[11] ? ST_FMUL : ST_FRAC;
      end
      ST_FMUL: begin
        if (!alu_stat.busy) begin
          alu_cmd.start = 1'b1;
          alu_a         = W'(root);
          alu_b         = W'(curve);
          state_next    = ST_FMUL_WAIT;
        end
      end
      ST_FMUL_WAIT: if (alu_stat.done) state_next = ST_FRAC;
      ST_MAG: begin
        if (!alu_stat.busy) begin
          alu_cmd.start = 1'b1;
          alu_a         = W'(gap_mag);
          alu_b         = W'(curve);
          state_next    = ST_MAG_WAIT;
        end
      end
      ST_MAG_WAIT: if (alu_stat.done) state_next = ST_EMIT;
      ST_EMIT: if (!sample_valid || sample_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // segment state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      next_value     <= VW'(INIT_V);
      previous_value <= VW'(INIT_V);
      phase          <= PW'(INIT_P);
      held_exponent  <= '0;
      sample_valid   <= 1'b0;
    end else begin
      if (state == ST_SEG && phase > ONE_P) begin
        // start a new segment
        phase          <= '0;
        previous_value <= next_value;
        next_value     <= tent_next;
        held_exponent  <= exp_q;
      end
      if (state == ST_DIV_WAIT && alu_stat.done) begin
        phase <= phase + step_sat[PW-1:0];
      end
      if (state == ST_EMIT && (!sample_valid || sample_ready)) begin
        sample_valid <= 1'b1;
      end else if (sample_ready) begin
        sample_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      freq_q <= freq_hz;
      coef_q <= tent_coef;
      exp_q  <= curve_exp;
    end
    if (state == ST_CURVE) begin
      if (held_exponent == 16'd0) begin
        curve <= '0;
      end else if (held_exponent == EXP_ONE) begin
        curve <= RW'(phase);
      end else begin
        curve <= RW'(ONE_L);
      end
      pow_left  <= held_exponent[15:12];
      frac_left <= held_exponent[11:0];
      root      <= phase;
    end
    if (state == ST_POW_WAIT && alu_stat.done) begin
      curve    <= alu_res[RW-1:0];
      pow_left <= pow_left - 1'b1;
    end
    if (state == ST_SQ_WAIT && alu_stat.done) begin
      root <= alu_res[PW-1:0];
      if (!frac_left[11]) frac_left <= frac_left << 1;
    end
    if (state == ST_FMUL_WAIT && alu_stat.done) begin
      curve     <= alu_res[RW-1:0];
      frac_left <= frac_left << 1;
    end
    if (state == ST_MAG_WAIT && alu_stat.done) begin
      mag <= alu_res[RW-1:0];
    end
    if (state == ST_EMIT && (!sample_valid || sample_ready)) begin
      sample <= sample_next;
    end
  end

  tmco_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .opa    (alu_a),
    .opb    (alu_b),
    .result (alu_res),
    .stat   (alu_stat)
  );

endmodule
`default_nettype wire

FILE: rtl/core/tmco_checker.sv
// Port-level checker for the tent-map oscillator, bound to the top level.
`default_nettype none
module tmco_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        sample_valid,
  input wire logic        sample_ready,
  input wire logic [23:0] sample,
  input wire logic        pready
);

  // the block works one item at a time
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous item still in work");

  a_sample_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> sample_valid && $stable(sample))
    else $error("stalled sample beat dropped or changed");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !sample_valid && item_ready)
    else $error("block not idle after reset");

  a_no_wait: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("configuration port inserted a wait state");

endmodule

bind tent_map_chaotic_oscillator tmco_checker u_tmco_checker (.*);
`default_nettype wire
